[hw/rtl/tsfh_pkg.sv]
`default_nettype none
package tsfh_pkg;

	localparam int FRAC_BITS = 26;
	localparam int TERM_COUNT = 17;

	localparam int ROM_TERMS = 17;
	localparam int ROM_FRAC = 48;
	localparam int MANT_W = 24;
	localparam int SHIFT_W = 5;
	localparam int TERMS = (TERM_COUNT > ROM_TERMS) ? ROM_TERMS : TERM_COUNT;
	localparam int TERM_IDX_W = $clog2(ROM_TERMS);

	localparam int ANGLE_W = 28;
	localparam int TAN_W = 29;
	localparam int ACC_W = 64;
	localparam int HALF_W = ACC_W / 2;
	localparam int SQR_PROD_W = 2 * ANGLE_W;
	localparam int SQ_W = SQR_PROD_W - 1 - FRAC_BITS;
	localparam int OUT_TOP_W = FRAC_BITS + TAN_W;

	localparam logic [MANT_W-1:0] ROM_MANT [ROM_TERMS] = '{
		24'd8388608, 24'd11184810, 24'd8947846, 24'd14486993, 24'd11741092,
		24'd9516827, 24'd15428073, 24'd12505523, 24'd10136594, 24'd16432829,
		24'd13319948, 24'd10796742, 24'd8751510, 24'd14187414, 24'd11499884,
		24'd9321455, 24'd15111373
	};

	localparam logic [SHIFT_W-1:0] ROM_SHIFT [ROM_TERMS] = '{
		5'd25, 5'd23, 5'd22, 5'd20, 5'd19, 5'd18, 5'd16, 5'd15, 5'd14,
		5'd12, 5'd11, 5'd10, 5'd9, 5'd7, 5'd6, 5'd5, 5'd3
	};

	typedef struct packed {
		logic [ANGLE_W-1:0] x;
		logic [SQ_W-1:0]    sq;
		logic [ACC_W-1:0]   acc;
	} lane_t;

	// Each coefficient is held exactly as mantissa and shift; scaling down to
	// the working format truncates toward zero.
	function automatic logic [ACC_W-1:0] coef(input logic [TERM_IDX_W-1:0] k);
		logic [ACC_W-1:0] exact;
		exact = ACC_W'(ROM_MANT[k]) << ROM_SHIFT[k];
		return exact >> (ROM_FRAC - FRAC_BITS);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/tsfh_square.sv]
`default_nettype none
module tsfh_square (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic [tsfh_pkg::ANGLE_W-1:0]        in_angle,
	output logic                                     out_valid,
	output tsfh_pkg::lane_t                          out_lane
);

	logic                                 valid_s1;
	logic [tsfh_pkg::ANGLE_W-1:0]         x_s1;
	logic signed [tsfh_pkg::SQR_PROD_W-1:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= in_angle;
		prod_s1 <= $signed(in_angle) * $signed(in_angle);
	end

	assign out_valid   = valid_s1;
	assign out_lane.x  = x_s1;
	assign out_lane.sq = prod_s1[tsfh_pkg::SQ_W+tsfh_pkg::FRAC_BITS-1:tsfh_pkg::FRAC_BITS];
	assign out_lane.acc = '0;

endmodule
`default_nettype wire

[hw/rtl/tsfh_cell.sv]
`default_nettype none
module tsfh_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire tsfh_pkg::lane_t             in_lane,
	input  wire logic [tsfh_pkg::ACC_W-1:0]  coef,
	output logic                             out_valid,
	output tsfh_pkg::lane_t                  out_lane
);

	localparam int LO_PROD_W = tsfh_pkg::HALF_W + tsfh_pkg::SQ_W;

	logic                           valid_s1;
	logic                           valid_s2;
	logic                           valid_s3;
	tsfh_pkg::lane_t                lane_s1;
	tsfh_pkg::lane_t                lane_s2;
	tsfh_pkg::lane_t                lane_s3;
	logic [LO_PROD_W-1:0]           plo_s1;
	logic [tsfh_pkg::HALF_W-1:0]    phi_s1;
	logic [tsfh_pkg::ACC_W-1:0]     prod_s2;
	logic [LO_PROD_W-1:0]           phi_full;
	logic [LO_PROD_W-1:0]           plo_next;
	logic [tsfh_pkg::ACC_W-1:0]     sum_next;
	logic [tsfh_pkg::ACC_W-1:0]     acc_next;

	// The product is kept modulo the accumulator width, built from two halves.
	always_comb begin
		plo_next = in_lane.acc[tsfh_pkg::HALF_W-1:0] * in_lane.sq;
		phi_full = in_lane.acc[tsfh_pkg::ACC_W-1:tsfh_pkg::HALF_W] * in_lane.sq;
		sum_next = {{(tsfh_pkg::ACC_W-LO_PROD_W){1'b0}}, plo_s1}
			+ {phi_s1, {tsfh_pkg::HALF_W{1'b0}}};
		acc_next = tsfh_pkg::ACC_W'($signed(prod_s2) >>> tsfh_pkg::FRAC_BITS) + coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= in_lane;
		plo_s1  <= plo_next;
		phi_s1  <= phi_full[tsfh_pkg::HALF_W-1:0];
		lane_s2 <= lane_s1;
		prod_s2 <= sum_next;
		lane_s3.x   <= lane_s2.x;
		lane_s3.sq  <= lane_s2.sq;
		lane_s3.acc <= acc_next;
	end

	assign out_valid = valid_s3;
	assign out_lane  = lane_s3;

endmodule
`default_nettype wire

[hw/rtl/tsfh_final.sv]
`default_nettype none
module tsfh_final (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire tsfh_pkg::lane_t             in_lane,
	output logic                             out_valid,
	output logic [tsfh_pkg::TAN_W-1:0]       out_tangent
);

	localparam int HI_W = tsfh_pkg::OUT_TOP_W - tsfh_pkg::HALF_W;
	localparam int LO_PROD_W = tsfh_pkg::HALF_W + 1 + tsfh_pkg::ANGLE_W;
	localparam int HI_PROD_W = HI_W + 1 + tsfh_pkg::ANGLE_W;

	logic                              valid_s1;
	logic                              valid_s2;
	logic [tsfh_pkg::OUT_TOP_W-1:0]    plo_s1;
	logic [HI_W-1:0]                   phi_s1;
	logic [tsfh_pkg::TAN_W-1:0]        tangent_s2;
	logic signed [LO_PROD_W-1:0]       plo_full;
	logic signed [HI_PROD_W-1:0]       phi_full;
	logic [tsfh_pkg::OUT_TOP_W-1:0]    sum;

	always_comb begin
		plo_full = $signed({1'b0, in_lane.acc[tsfh_pkg::HALF_W-1:0]})
			* $signed(in_lane.x);
		phi_full = $signed({1'b0, in_lane.acc[tsfh_pkg::OUT_TOP_W-1:tsfh_pkg::HALF_W]})
			* $signed(in_lane.x);
		sum = plo_s1 + {phi_s1, {tsfh_pkg::HALF_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		plo_s1     <= plo_full[tsfh_pkg::OUT_TOP_W-1:0];
		phi_s1     <= phi_full[HI_W-1:0];
		tangent_s2 <= sum[tsfh_pkg::OUT_TOP_W-1:tsfh_pkg::FRAC_BITS];
	end

	assign out_valid   = valid_s2;
	assign out_tangent = tangent_s2;

endmodule
`default_nettype wire

[hw/rtl/tan_series_fixed_horner.sv]
`default_nettype none
// Tangent of a signed Q26 angle, returned in Q26, from a 17-term odd Taylor
// series evaluated by Horner's rule in the squared angle. The block takes a
// new angle in every cycle and busy stays low. The pipeline is one squaring
// stage, a chain of 17 Horner cells of three stages each, and a two-stage
// final multiply by the angle, 54 register stages in all. done is high in the
// cycle in which the tangent for an angle leaves the last of these stages.
// Results cannot be held off by the receiver.
// Angles beyond one radian are not saturated; arithmetic wraps at 64 bits.
module tan_series_fixed_horner (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [tsfh_pkg::ANGLE_W-1:0]   angle,
	output logic                                done,
	output logic [tsfh_pkg::TAN_W-1:0]          tangent
);

	logic            valid [tsfh_pkg::TERMS+1];
	tsfh_pkg::lane_t lane  [tsfh_pkg::TERMS+1];

	assign busy = 1'b0;

	tsfh_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_angle  (angle),
		.out_valid (valid[0]),
		.out_lane  (lane[0])
	);

	for (genvar g = 0; g < tsfh_pkg::TERMS; g++) begin : g_cell
		tsfh_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[g]),
			.in_lane   (lane[g]),
			.coef      (tsfh_pkg::coef(tsfh_pkg::TERM_IDX_W'(tsfh_pkg::TERMS - 1 - g))),
			.out_valid (valid[g+1]),
			.out_lane  (lane[g+1])
		);
	end

	tsfh_final u_final (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid[tsfh_pkg::TERMS]),
		.in_lane     (lane[tsfh_pkg::TERMS]),
		.out_valid   (done),
		.out_tangent (tangent)
	);

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
	import tsfh_pkg::*;

	localparam int ONE = 1 << FRAC_BITS;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_ITEMS = 1140;
	localparam int SERIES_FRAC = 48;

	localparam int unsigned SERIES_MANT [17] = '{
		8388608, 11184810, 8947846, 14486993, 11741092, 9516827, 15428073,
		12505523, 10136594, 16432829, 13319948, 10796742, 8751510, 14187414,
		11499884, 9321455, 15111373
	};
	localparam int SERIES_SHIFT [17] = '{
		25, 23, 22, 20, 19, 18, 16, 15, 14, 12, 11, 10, 9, 7, 6, 5, 3
	};

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               known;
		logic [TAN_W-1:0]   tangent;
	} angle_row_t;

	localparam angle_row_t DIRECTED [12] = '{
		'{ANGLE_W'(0),                 1'b1, TAN_W'(0)},
		'{ANGLE_W'(1),                 1'b1, TAN_W'(1)},
		'{{ANGLE_W{1'b1}},             1'b1, {TAN_W{1'b1}}},
		'{ANGLE_W'(ONE),               1'b0, TAN_W'(0)},
		'{ANGLE_W'(-ONE),              1'b0, TAN_W'(0)},
		'{ANGLE_W'(ONE / 2),           1'b0, TAN_W'(0)},
		'{ANGLE_W'(-(ONE / 2)),        1'b0, TAN_W'(0)},
		'{ANGLE_W'(ONE - 1),           1'b0, TAN_W'(0)},
		'{{1'b0, {(ANGLE_W-1){1'b1}}}, 1'b0, TAN_W'(0)},
		'{{1'b1, {(ANGLE_W-1){1'b0}}}, 1'b0, TAN_W'(0)},
		'{ANGLE_W'(28'h5555555),       1'b0, TAN_W'(0)},
		'{ANGLE_W'(28'hAAAAAAA),       1'b0, TAN_W'(0)}
	};

	localparam int IDLE_PCT [3] = '{0, 53, 16};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [ANGLE_W-1:0] angle;
	logic done;
	logic [TAN_W-1:0] tangent;

	logic [TAN_W-1:0] tangent_q [$];
	logic [TAN_W-1:0] expected_tangent;
	int fail_count = 0;
	int quiet_cycles = 0;
	int idle_pct = 0;

	tan_series_fixed_horner dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.angle(angle),
		.done(done),
		.tangent(tangent)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint scaled_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return p >>> FRAC_BITS;
	endfunction

	function automatic logic [TAN_W-1:0] tangent_of(input logic [ANGLE_W-1:0] a);
		longint x;
		longint sq;
		longint acc;
		longint c;
		int k;
		x = {{(64-ANGLE_W){a[ANGLE_W-1]}}, a};
		sq = scaled_mul(x, x);
		acc = 0;
		for (k = TERMS - 1; k >= 0; k--) begin
			c = (longint'(SERIES_MANT[k]) << SERIES_SHIFT[k]) >> (SERIES_FRAC - FRAC_BITS);
			acc = scaled_mul(acc, sq) + c;
		end
		acc = scaled_mul(acc, x);
		return acc[TAN_W-1:0];
	endfunction

	function automatic logic [ANGLE_W-1:0] random_angle();
		int v;
		case ($urandom_range(9))
			0: begin
				v = $urandom();
				return v[ANGLE_W-1:0];
			end
			1: begin
				v = $urandom_range(1) ? ONE : -ONE;
				return v[ANGLE_W-1:0];
			end
			default: begin
				v = int'($urandom_range(2 * ONE)) - ONE;
				return v[ANGLE_W-1:0];
			end
		endcase
	endfunction

	task automatic transfer(input logic [ANGLE_W-1:0] a, input logic known,
			input logic [TAN_W-1:0] t);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		angle <= a;
		@(posedge clk);
		while (busy) @(posedge clk);
		tangent_q.push_back(known ? t : tangent_of(a));
	endtask

	// Hold off the next transfer until every outstanding tangent has come back.
	task automatic drain_tangents();
		start <= 1'b0;
		while (tangent_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (tangent_q.size() == 0) begin
					$error("tangent: expected none, actual %0h", tangent);
					fail_count++;
				end else begin
					expected_tangent = tangent_q.pop_front();
					if (tangent !== expected_tangent) begin
						$error("tangent: expected %0h, actual %0h", expected_tangent, tangent);
						fail_count++;
					end
				end
			end
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		angle <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 0;
		foreach (DIRECTED[i])
			transfer(DIRECTED[i].angle, DIRECTED[i].known, DIRECTED[i].tangent);
		drain_tangents();
		foreach (IDLE_PCT[p]) begin
			idle_pct = IDLE_PCT[p];
			repeat (RANDOM_ITEMS / 3) transfer(random_angle(), 1'b0, '0);
			drain_tangents();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
